// File: hdl/rgbled_pkg.sv
// Shared types and constants for the serial RGB LED line encoder.
`default_nettype none

package rgbled_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_SHIFT      = 3'd1,
    CFG_ZERO_HIGH  = 3'd2,
    CFG_ZERO_LOW   = 3'd3,
    CFG_ONE_HIGH   = 3'd4,
    CFG_ONE_LOW    = 3'd5,
    CFG_LATCH      = 3'd6
  } cfg_index_t;

  // Reset values of the configuration registers
  localparam logic [2:0]  RST_SHIFT     = 3'd3;
  localparam logic [15:0] RST_ZERO_HIGH = 16'd35;
  localparam logic [15:0] RST_ZERO_LOW  = 16'd80;
  localparam logic [15:0] RST_ONE_HIGH  = 16'd70;
  localparam logic [15:0] RST_ONE_LOW   = 16'd60;
  localparam logic [15:0] RST_LATCH     = 16'd6000;

  // Frame length in bits
  localparam logic [4:0] FRAME_BITS = 5'd24;

  // Line phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  // Configuration register set
  typedef struct packed {
    logic        enable;
    logic [2:0]  brightness_shift;
    logic [15:0] zero_high_ticks;
    logic [15:0] zero_low_ticks;
    logic [15:0] one_high_ticks;
    logic [15:0] one_low_ticks;
    logic [15:0] latch_ticks;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/rgbled_core.sv
// Bit timing sequencer: advances the line state by one clock per accepted item.
`default_nettype none

module rgbled_core #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 step,
  input  wire                 op,
  input  wire [7:0]           red,
  input  wire [7:0]           green,
  input  wire [7:0]           blue,
  input  rgbled_pkg::cfg_t    cfg,
  output rgbled_pkg::res_t    res
);
  import rgbled_pkg::*;

  localparam int unsigned WIDE = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
  localparam logic [WIDE-1:0] CNT_MAX_W = WIDE'(CNT_MAX);

  phase_t                  phase, phase_next;
  logic [23:0]             colour_shift_reg, colour_shift_reg_next;
  logic [4:0]              bits_left, bits_left_next;
  logic [COUNTER_BITS-1:0] tick_count, tick_count_next;
  logic                    load;
  logic [23:0]             shifted;

  // Clocks left in a phase after its first clock, zero treated as one, saturated
  function automatic logic [COUNTER_BITS-1:0] remain(input logic [15:0] ticks);
    logic [15:0]     d;
    logic [WIDE-1:0] dw;
    d  = (ticks == 16'd0) ? 16'd0 : ticks - 16'd1;
    dw = WIDE'(d);
    if (dw > CNT_MAX_W) begin
      return CNT_MAX;
    end
    return dw[COUNTER_BITS-1:0];
  endfunction

  assign load    = op && cfg.enable && (phase == PH_IDLE);
  assign shifted = {green >> cfg.brightness_shift,
                    red   >> cfg.brightness_shift,
                    blue  >> cfg.brightness_shift};

  // Next line state for one clock of line time
  always_comb begin
    phase_next            = phase;
    colour_shift_reg_next = colour_shift_reg;
    bits_left_next        = bits_left;
    tick_count_next       = tick_count;
    if (load) begin
      colour_shift_reg_next = shifted;
      bits_left_next        = FRAME_BITS;
      phase_next            = PH_HIGH;
      tick_count_next       = remain(shifted[23] ? cfg.one_high_ticks : cfg.zero_high_ticks);
    end else if (phase != PH_IDLE) begin
      if (tick_count != '0) begin
        tick_count_next = tick_count - COUNTER_BITS'(1);
      end else begin
        case (phase)
          PH_HIGH: begin
            phase_next      = PH_LOW;
            tick_count_next = remain(colour_shift_reg[23] ? cfg.one_low_ticks
                                                          : cfg.zero_low_ticks);
          end
          PH_LOW: begin
            if (bits_left > 5'd1) begin
              bits_left_next        = bits_left - 5'd1;
              colour_shift_reg_next = {colour_shift_reg[22:0], 1'b0};
              phase_next            = PH_HIGH;
              tick_count_next       = remain(colour_shift_reg[22] ? cfg.one_high_ticks
                                                                  : cfg.zero_high_ticks);
            end else begin
              bits_left_next  = 5'd0;
              phase_next      = PH_LATCH;
              tick_count_next = remain(cfg.latch_ticks);
            end
          end
          PH_LATCH: begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end
          default: begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end
        endcase
      end
    end
  end

  // Result of this clock follows the new phase
  always_comb begin
    res.line_level = (phase_next == PH_HIGH);
    res.busy_res   = (phase_next != PH_IDLE);
    res.accepted   = load;
  end

  // Hold state between items, advance on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      colour_shift_reg <= '0;
      bits_left        <= '0;
      tick_count       <= '0;
    end else if (step) begin
      phase            <= phase_next;
      colour_shift_reg <= colour_shift_reg_next;
      bits_left        <= bits_left_next;
      tick_count       <= tick_count_next;
    end
  end

  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0)
    else $error("idle phase with a running tick count");

  a_bits_in_frame: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HIGH || phase == PH_LOW) |-> (bits_left != 5'd0 && bits_left <= FRAME_BITS))
    else $error("bit phase without a bit left in the frame");

  a_load_starts_frame: assert property (@(posedge clk) disable iff (rst)
    step && load |=> phase == PH_HIGH && bits_left == FRAME_BITS)
    else $error("accepted colour did not start a frame");

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> !res.accepted)
    else $error("colour taken while a frame is running");

endmodule

`default_nettype wire

// File: hdl/rgbled_outbuf.sv
// Two-slot result buffer: output register plus skid register.
`default_nettype none

module rgbled_outbuf (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  rgbled_pkg::res_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  wire               out_stall,
  output rgbled_pkg::res_t  out_data
);
  import rgbled_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  // Move skid into the output slot when it frees, else park the new result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot filled while output slot empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid && $stable(skid_data))
    else $error("parked result lost under stall");

endmodule

`default_nettype wire

// File: hdl/rgb_led_one_wire_encoder.sv
// Top level of the serial RGB LED line encoder.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_stall    op, red, green, blue
//  out      source     out_valid/out_stall  line_level, busy_res, accepted
//  cfg      sink       cfg_write            cfg_index, cfg_data
//
// One item per clock while in_stall is low: each transfer is one clock of line time,
// computed in a single pass and registered into a two-slot output buffer.
// in_stall rises only when both buffer slots hold results.
// Reset (synchronous, rst high) sets the line idle and the registers to their defaults.
// Stalls on the output freeze line time, since time advances only on input transfers.
`default_nettype none

module rgb_led_one_wire_encoder #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  op,
  input  wire [7:0]                            red,
  input  wire [7:0]                            green,
  input  wire [7:0]                            blue,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic                                 line_level,
  output logic                                 busy_res,
  output logic                                 accepted,
  input  wire                                  cfg_write,
  input  wire [rgbled_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire [rgbled_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import rgbled_pkg::*;

  cfg_t cfg;
  res_t step_res;
  res_t out_data;
  logic full;
  logic step;

  assign in_stall = full;
  assign step     = in_valid && !full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable           <= 1'b0;
      cfg.brightness_shift <= RST_SHIFT;
      cfg.zero_high_ticks  <= RST_ZERO_HIGH;
      cfg.zero_low_ticks   <= RST_ZERO_LOW;
      cfg.one_high_ticks   <= RST_ONE_HIGH;
      cfg.one_low_ticks    <= RST_ONE_LOW;
      cfg.latch_ticks      <= RST_LATCH;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_ENABLE:    cfg.enable           <= cfg_data[0];
        CFG_SHIFT:     cfg.brightness_shift <= cfg_data[2:0];
        CFG_ZERO_HIGH: cfg.zero_high_ticks  <= cfg_data;
        CFG_ZERO_LOW:  cfg.zero_low_ticks   <= cfg_data;
        CFG_ONE_HIGH:  cfg.one_high_ticks   <= cfg_data;
        CFG_ONE_LOW:   cfg.one_low_ticks    <= cfg_data;
        CFG_LATCH:     cfg.latch_ticks      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rgbled_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .op    (op),
    .red   (red),
    .green (green),
    .blue  (blue),
    .cfg   (cfg),
    .res   (step_res)
  );

  rgbled_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (step_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign line_level = out_data.line_level;
  assign busy_res   = out_data.busy_res;
  assign accepted   = out_data.accepted;

endmodule

`default_nettype wire

// File: test/tb_rgb_led_one_wire_encoder.sv
// Testbench for the serial RGB LED line encoder: directed and random transfers checked per clock.
`default_nettype none

module tb_rgb_led_one_wire_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbled_pkg::*;

  localparam int          CNT_BITS     = 16;
  localparam int unsigned CNT_MAX      = (1 << CNT_BITS) - 1;
  localparam bit          OP_TICK      = 1'b0;
  localparam bit          OP_SET       = 1'b1;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  // Line-level predictor and queue of results still due from the encoder
  class led_line_scoreboard;
    bit                enable;
    bit [2:0]          shift;
    bit [15:0]         zero_high;
    bit [15:0]         zero_low;
    bit [15:0]         one_high;
    bit [15:0]         one_low;
    bit [15:0]         latch;
    phase_t            phase;
    bit [23:0]         frame;
    bit [4:0]          bits_left;
    bit [CNT_BITS-1:0] ticks;
    res_t              due_levels[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      enable    = 1'b0;
      shift     = RST_SHIFT;
      zero_high = RST_ZERO_HIGH;
      zero_low  = RST_ZERO_LOW;
      one_high  = RST_ONE_HIGH;
      one_low   = RST_ONE_LOW;
      latch     = RST_LATCH;
      phase     = PH_IDLE;
      frame     = '0;
      bits_left = '0;
      ticks     = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void write_reg(cfg_index_t idx, bit [15:0] val);
      case (idx)
        CFG_ENABLE:    enable    = val[0];
        CFG_SHIFT:     shift     = val[2:0];
        CFG_ZERO_HIGH: zero_high = val;
        CFG_ZERO_LOW:  zero_low  = val;
        CFG_ONE_HIGH:  one_high  = val;
        CFG_ONE_LOW:   one_low   = val;
        CFG_LATCH:     latch     = val;
        default: ;
      endcase
    endfunction

    // Clocks left after the first clock of a phase; zero length acts as one
    function bit [CNT_BITS-1:0] clocks_after_first(bit [15:0] len);
      int unsigned rest;
      rest = (len == 0) ? 0 : len - 1;
      if (rest > CNT_MAX) rest = CNT_MAX;
      return rest[CNT_BITS-1:0];
    endfunction

    function void enter_bit_high();
      phase = PH_HIGH;
      ticks = clocks_after_first(frame[23] ? one_high : zero_high);
    endfunction

    // Move line time forward by one clock
    function void advance_line_clock();
      if (phase == PH_IDLE) return;
      if (ticks != 0) begin
        ticks--;
        return;
      end
      case (phase)
        PH_HIGH: begin
          phase = PH_LOW;
          ticks = clocks_after_first(frame[23] ? one_low : zero_low);
        end
        PH_LOW: begin
          if (bits_left > 1) begin
            bits_left--;
            frame = frame << 1;
            enter_bit_high();
          end else begin
            bits_left = '0;
            phase     = PH_LATCH;
            ticks     = clocks_after_first(latch);
          end
        end
        default: begin
          phase = PH_IDLE;
          ticks = '0;
        end
      endcase
    endfunction

    // Predict the line for one accepted input transfer
    function void note_item(bit item_op, bit [7:0] r, bit [7:0] g, bit [7:0] b);
      res_t want;
      want.accepted = 1'b0;
      if (item_op == OP_SET && enable && phase == PH_IDLE) begin
        frame     = {g >> shift, r >> shift, b >> shift};
        bits_left = FRAME_BITS;
        enter_bit_high();
        want.accepted = 1'b1;
      end else begin
        advance_line_clock();
      end
      want.line_level = (phase == PH_HIGH);
      want.busy_res   = (phase != PH_IDLE);
      due_levels.push_back(want);
    endfunction

    // Compare one output transfer against the oldest prediction
    function void check_level(res_t got);
      res_t want;
      if (due_levels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: line=%0b busy=%0b acc=%0b",
                   got.line_level, got.busy_res, got.accepted);
        return;
      end
      want = due_levels.pop_front();
      if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
          got.accepted !== want.accepted) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"result %0d mismatch: expected line=%0b busy=%0b acc=%0b, ",
                    "got line=%0b busy=%0b acc=%0b"},
                   checked, want.line_level, want.busy_res, want.accepted,
                   got.line_level, got.busy_res, got.accepted);
      end
      checked++;
    endfunction

    function int unsigned pending();
      return due_levels.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst        = 1'b1;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic                      op         = 1'b0;
  logic [7:0]                red        = '0;
  logic [7:0]                green      = '0;
  logic [7:0]                blue       = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic                      line_level;
  logic                      busy_res;
  logic                      accepted;
  logic                      cfg_write  = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data   = '0;

  led_line_scoreboard sb;
  bit                 quiet    = 1'b0;
  bit                 hold_req = 1'b0;
  int unsigned        items_sent = 0;

  rgb_led_one_wire_encoder #(
    .COUNTER_BITS(CNT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .line_level(line_level),
    .busy_res  (busy_res),
    .accepted  (accepted),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one input transfer and wait until it is taken
  task automatic send_item(bit item_op, bit [7:0] r, bit [7:0] g, bit [7:0] b);
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= item_op;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(item_op, r, g, b);
    items_sent++;
  endtask

  task automatic send_random(bit item_op);
    send_item(item_op, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  // Clock the encoder until the frame and latch are over, mixing in refused sets
  task automatic run_frame_out(int unsigned set_pct);
    while (sb.phase != PH_IDLE)
      send_random(($urandom_range(99) < set_pct) ? OP_SET : OP_TICK);
  endtask

  // Drop valid and wait for every predicted result
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, bit [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [15:0] random_ticks();
    if ($urandom_range(7) == 0) return 16'($urandom_range(4, 24));
    return 16'($urandom_range(0, 3));
  endfunction

  // Drain output transfers and stall at random, with one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_level({line_level, busy_res, accepted});
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 9);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned round;
    int unsigned random_start;
    bit [15:0]   noise;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Set while disabled acts as a plain clock; idle ticks show a quiet line
    send_item(OP_SET, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_TICK, 8'h00, 8'h00, 8'h00);
    settle();

    // Short timings, zero high length, full-scale channels, refused set while busy
    write_reg(CFG_ENABLE, 16'h0001);
    write_reg(CFG_SHIFT, 16'h0000);
    write_reg(CFG_ZERO_HIGH, 16'h0000);
    write_reg(CFG_ZERO_LOW, 16'h0002);
    write_reg(CFG_ONE_HIGH, 16'h0002);
    write_reg(CFG_ONE_LOW, 16'h0001);
    write_reg(CFG_LATCH, 16'h0003);
    send_item(OP_SET, 8'hFF, 8'h00, 8'hA5);
    send_item(OP_SET, 8'h5A, 8'hFF, 8'h00);
    run_frame_out(0);
    send_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // Largest brightness shift leaves only the top bit of each channel
    write_reg(CFG_SHIFT, 16'h0007);
    send_item(OP_SET, 8'hFF, 8'h80, 8'h7F);
    run_frame_out(0);
    settle();

    // Clear enable part way through a frame: frame and latch still finish
    write_reg(CFG_SHIFT, 16'h0001);
    send_item(OP_SET, 8'hC3, 8'h3C, 8'h81);
    repeat (5) send_random(OP_TICK);
    settle();
    write_reg(CFG_ENABLE, 16'h0000);
    run_frame_out(20);
    send_item(OP_SET, 8'h12, 8'h34, 8'h56);
    settle();
    write_reg(CFG_ENABLE, 16'h0001);

    // Longest one-bit lengths and a long latch; channels shift down to all zero bits
    write_reg(CFG_SHIFT, 16'h0007);
    write_reg(CFG_ZERO_LOW, 16'h0001);
    write_reg(CFG_ONE_HIGH, 16'hFFFF);
    write_reg(CFG_ONE_LOW, 16'hFFFF);
    write_reg(CFG_LATCH, 16'h00C8);
    send_item(OP_SET, 8'h7F, 8'h7F, 8'h7F);
    run_frame_out(1);
    settle();

    // Longest zero-bit lengths unused by an all-ones frame; one high and latch of one, one low of zero
    write_reg(CFG_SHIFT, 16'h0000);
    write_reg(CFG_ZERO_HIGH, 16'hFFFF);
    write_reg(CFG_ZERO_LOW, 16'hFFFF);
    write_reg(CFG_ONE_HIGH, 16'h0001);
    write_reg(CFG_ONE_LOW, 16'h0000);
    write_reg(CFG_LATCH, 16'h0001);
    send_item(OP_SET, 8'hFF, 8'hFF, 8'hFF);
    run_frame_out(0);
    send_item(OP_TICK, 8'h00, 8'h00, 8'h00);

    // Random settings, each followed by whole frames with random colours
    round = 0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      settle();
      quiet = (round == 1);
      noise = 16'($urandom);
      if (round % 6 == 5) begin
        // Disabled: every item is a plain clock
        write_reg(CFG_ENABLE, {noise[15:1], 1'b0});
        repeat (10) send_random(1'($urandom_range(1)));
      end else begin
        write_reg(CFG_ENABLE, {noise[15:1], 1'b1});
        write_reg(CFG_SHIFT, {noise[15:3], 3'($urandom_range(7))});
        write_reg(CFG_ZERO_HIGH, random_ticks());
        write_reg(CFG_ZERO_LOW, random_ticks());
        write_reg(CFG_ONE_HIGH, random_ticks());
        write_reg(CFG_ONE_LOW, random_ticks());
        write_reg(CFG_LATCH, 16'($urandom_range(0, 12)));
        if (round == 0) hold_req = 1'b1;
        repeat ($urandom_range(1, 3)) begin
          repeat ($urandom_range(2)) send_random(OP_TICK);
          send_random(OP_SET);
          if ($urandom_range(3) == 0) begin
            // Drop enable mid-frame, then restore it once idle
            repeat ($urandom_range(1, 30)) send_random(OP_TICK);
            settle();
            write_reg(CFG_ENABLE, 16'h0000);
            run_frame_out(10);
            send_random(OP_SET);
            settle();
            write_reg(CFG_ENABLE, 16'h0001);
          end else begin
            run_frame_out(8);
          end
        end
      end
      round++;
    end
    quiet = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
